>>> rtl/bsrt_pkg.sv
// Shared constants, codes and command/status types of the radius search table.
package bsrt_pkg;

  // Store geometry
  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 16;
  localparam int RAD_W   = 15;
  localparam int ID_W    = 6;
  localparam int ST_W    = 2;

  // Distance arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int CMP_W  = DIFF_W + RAD_W;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int SUM_W  = SQ_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_GET   = 2'd1,
    OP_QUERY = 2'd2
  } bsrt_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } bsrt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_GET,
    S_GET_OUT,
    S_SCAN,
    S_DRAIN
  } bsrt_state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } bsrt_point_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic add_emit;
    logic get_read;
    logic get_emit;
    logic scan_issue;
    logic final_emit;
  } bsrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic id_hit;
    logic scan_end;
    logic pipe_empty;
    logic out_free;
  } bsrt_stat_t;

endpackage

>>> rtl/bsrt_if.sv
// Request and result channel interfaces of the radius search table.
interface bsrt_in_if import bsrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [RAD_W-1:0]          search_radius;
  logic [ID_W-1:0]           query_id;

  modport source (output valid, op, pos_x, pos_y, search_radius, query_id, input ready);
  modport sink   (input valid, op, pos_x, pos_y, search_radius, query_id, output ready);
endinterface

interface bsrt_out_if import bsrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ST_W-1:0]           status;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [ID_W-1:0]           point_id;
  logic                      last;

  modport source (output valid, status, point_x, point_y, point_id, last, input ready);
  modport sink   (input valid, status, point_x, point_y, point_id, last, output ready);
endinterface

>>> rtl/beacon_radius_search_table_unit.sv
// Top level of the radius search table: sequencer plus datapath.
// Add: result registered from the add state; get by id: from the get or get-out state.
// Range query: the single read port of the point store scans one point per cycle, but
// a hit that must displace the pending one stalls the scan while the result slot is busy.
// One item is in work at a time; the next item is taken once the last result is registered.
// Reset clears the fill count and all control state; the store is not cleared.
module beacon_radius_search_table_unit import bsrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bsrt_in_if.sink  in_i,
  bsrt_out_if.source out_o
);

  bsrt_cmd_t  cmd;
  bsrt_stat_t stat;

  bsrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsrt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pos_x_i         (in_i.pos_x),
    .pos_y_i         (in_i.pos_y),
    .search_radius_i (in_i.search_radius),
    .query_id_i      (in_i.query_id),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .point_x_o       (out_o.point_x),
    .point_y_o       (out_o.point_y),
    .point_id_o      (out_o.point_id),
    .last_o          (out_o.last)
  );

endmodule

>>> rtl/bsrt_ctrl.sv
// Operation sequencer of the radius search table.
module bsrt_ctrl import bsrt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  bsrt_stat_t      stat_i,
  output bsrt_cmd_t       cmd_o
);

  bsrt_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (bsrt_op_e'(in_op_i))
            OP_ADD:   state_d = S_ADD;
            OP_GET:   state_d = S_GET;
            OP_QUERY: state_d = S_SCAN;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_GET: begin
        if (stat_i.id_hit) state_d = S_GET_OUT;
        else if (stat_i.out_free) state_d = S_IDLE;
      end
      S_GET_OUT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_end) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat_i.pipe_empty && stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    cmd_o            = '0;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.add_emit   = (state_q == S_ADD) && stat_i.out_free;
    cmd_o.get_read   = (state_q == S_GET) && stat_i.id_hit;
    cmd_o.get_emit   = ((state_q == S_GET) && !stat_i.id_hit && stat_i.out_free) ||
                       ((state_q == S_GET_OUT) && stat_i.out_free);
    cmd_o.scan_issue = (state_q == S_SCAN) && !stat_i.scan_end;
    cmd_o.final_emit = (state_q == S_DRAIN) && stat_i.pipe_empty && stat_i.out_free;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/bsrt_datapath.sv
// Point store, distance pipeline, pending-hit register and result register.
module bsrt_datapath import bsrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic [RAD_W-1:0]          search_radius_i,
  input  logic [ID_W-1:0]           query_id_i,
  input  bsrt_cmd_t                 cmd_i,
  output bsrt_stat_t                stat_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ST_W-1:0]           status_o,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic [ID_W-1:0]           point_id_o,
  output logic                      last_o
);

  // Latched request
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [RAD_W-1:0]             r_q;
  logic [SQ_W-1:0]              r2_q;
  logic [ID_W-1:0]              qid_q;

  // Store and counters
  bsrt_point_t    mem [CAPACITY];
  bsrt_point_t    rdata_q;
  logic [CNT_W-1:0] cnt_q, idx_q;

  // Pipeline
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic [IDX_W-1:0] s1_id_q, s2_id_q, s3_id_q;
  bsrt_point_t      s2_pt_q, s3_pt_q;
  logic             s2_box_q, s3_box_q;
  logic [RAD_W-1:0] s2_ax_q, s2_ay_q;
  logic [SQ_W-1:0]  s3_sqx_q, s3_sqy_q;

  // Pending hit
  logic             pend_v_q;
  bsrt_point_t      pend_pt_q;
  logic [IDX_W-1:0] pend_id_q;

  // Result register
  logic                      out_v_q;
  logic [ST_W-1:0]           out_st_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic [ID_W-1:0]           out_id_q;
  logic                      out_last_q;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax, ay;
  logic                     box;
  logic [SUM_W-1:0]         dist2;
  logic                     s3_hit, out_free, pipe_en, push, rd_scan, mem_rd;
  logic                     full, id_hit;
  logic [IDX_W-1:0]         rd_addr;

  logic                      emit;
  bsrt_status_e              e_st;
  logic signed [COORD_W-1:0] e_x, e_y;
  logic [ID_W-1:0]           e_id;
  logic                      e_last;

  // Status toward the controller
  assign full     = (cnt_q == CNT_W'(CAPACITY));
  assign id_hit   = (CNT_W'(qid_q) < cnt_q);
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    stat_o            = '0;
    stat_o.id_hit     = id_hit;
    stat_o.scan_end   = (idx_q == cnt_q);
    stat_o.pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;
    stat_o.out_free   = out_free;
  end

  // Stage 1: component distances and the box test
  always_comb begin
    dx  = DIFF_W'(rdata_q.x) - DIFF_W'(qx_q);
    dy  = DIFF_W'(rdata_q.y) - DIFF_W'(qy_q);
    ax  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    box = (CMP_W'(ax) < CMP_W'(r_q)) && (CMP_W'(ay) < CMP_W'(r_q));
  end

  // Stage 3: squared distance against squared radius
  assign dist2  = SUM_W'(s3_sqx_q) + SUM_W'(s3_sqy_q);
  assign s3_hit = s3_v_q && s3_box_q && (dist2 < SUM_W'(r2_q));

  // Stall the scan only when a hit must displace the pending one and the result slot is busy
  assign pipe_en = !(s3_hit && pend_v_q && !out_free);
  assign push    = s3_hit && pend_v_q && out_free;
  assign rd_scan = cmd_i.scan_issue && pipe_en;
  assign mem_rd  = rd_scan || cmd_i.get_read;
  assign rd_addr = cmd_i.get_read ? qid_q[IDX_W-1:0] : idx_q[IDX_W-1:0];

  // Select the result to emit
  always_comb begin
    emit   = 1'b0;
    e_st   = ST_NONE;
    e_x    = '0;
    e_y    = '0;
    e_id   = '0;
    e_last = 1'b1;
    if (cmd_i.add_emit) begin
      emit = 1'b1;
      if (full) begin
        e_st = ST_FULL;
      end else begin
        e_st = ST_OK;
        e_x  = COORD_W'(qx_q);
        e_y  = COORD_W'(qy_q);
        e_id = ID_W'(cnt_q);
      end
    end else if (cmd_i.get_emit) begin
      emit = 1'b1;
      if (id_hit) begin
        e_st = ST_OK;
        e_x  = COORD_W'(rdata_q.x);
        e_y  = COORD_W'(rdata_q.y);
        e_id = qid_q;
      end
    end else if (cmd_i.final_emit) begin
      emit = 1'b1;
      if (pend_v_q) begin
        e_st = ST_OK;
        e_x  = COORD_W'(pend_pt_q.x);
        e_y  = COORD_W'(pend_pt_q.y);
        e_id = ID_W'(pend_id_q);
      end
    end else if (push) begin
      emit   = 1'b1;
      e_st   = ST_OK;
      e_x    = COORD_W'(pend_pt_q.x);
      e_y    = COORD_W'(pend_pt_q.y);
      e_id   = ID_W'(pend_id_q);
      e_last = 1'b0;
    end
  end

  // Point store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_emit && !full) begin
      mem[cnt_q[IDX_W-1:0]] <= '{x: qx_q, y: qy_q};
    end
    if (mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Latch the request and keep the squared radius
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q  <= COORD_BITS'(pos_x_i);
      qy_q  <= COORD_BITS'(pos_y_i);
      r_q   <= search_radius_i;
      qid_q <= query_id_i;
    end
    r2_q <= SQ_W'(r_q) * SQ_W'(r_q);
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (rd_scan) begin
      s1_id_q <= idx_q[IDX_W-1:0];
    end
    if (pipe_en) begin
      s2_id_q  <= s1_id_q;
      s2_pt_q  <= rdata_q;
      s2_box_q <= box;
      s2_ax_q  <= RAD_W'(ax);
      s2_ay_q  <= RAD_W'(ay);
      s3_id_q  <= s2_id_q;
      s3_pt_q  <= s2_pt_q;
      s3_box_q <= s2_box_q;
      s3_sqx_q <= SQ_W'(s2_ax_q) * SQ_W'(s2_ax_q);
      s3_sqy_q <= SQ_W'(s2_ay_q) * SQ_W'(s2_ay_q);
    end
    if (pipe_en && s3_hit) begin
      pend_pt_q <= s3_pt_q;
      pend_id_q <= s3_id_q;
    end
    if (emit) begin
      out_st_q   <= e_st;
      out_x_q    <= e_x;
      out_y_q    <= e_y;
      out_id_q   <= e_id;
      out_last_q <= e_last;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.add_emit && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (rd_scan) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (pipe_en) begin
        s1_v_q <= rd_scan;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
      if (cmd_i.load || cmd_i.final_emit) begin
        pend_v_q <= 1'b0;
      end else if (pipe_en && s3_hit) begin
        pend_v_q <= 1'b1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_st_q;
  assign point_x_o   = out_x_q;
  assign point_y_o   = out_y_q;
  assign point_id_o  = out_id_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result emitted into a busy slot");

  // The scan never runs past the fill count
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_q) else $error("scan index beyond fill count");

  // A full store keeps its count
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.add_emit && full) |=> (cnt_q == $past(cnt_q)))
    else $error("count changed on a full add");

  // The closing result waits for the pipeline to drain
  a_final_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.final_emit |-> (!s1_v_q && !s2_v_q && !s3_v_q))
    else $error("closing result with hits still in flight");
`endif

endmodule

>>> test/tb_beacon_radius_search_table_unit.sv
// Self-checking testbench of the radius search table: directed and random items.
module tb_beacon_radius_search_table_unit import bsrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              CYCLE_LIMIT = 10_000_000;
  localparam int              DRAIN_WAIT  = 2 * CAPACITY + 20;
  localparam int              MAX_REPORTS = 10;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RAD_W-1:0]          search_radius;
    logic [ID_W-1:0]           query_id;
  } search_req_t;

  typedef struct {
    bsrt_status_e              status;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ID_W-1:0]           point_id;
    logic                      last;
  } search_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsrt_in_if  req_bus ();
  bsrt_out_if rsp_bus ();

  beacon_radius_search_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (rsp_bus)
  );

  // Shadow copy of the point store
  logic signed [COORD_W-1:0] shadow_x [CAPACITY];
  logic signed [COORD_W-1:0] shadow_y [CAPACITY];
  int                        point_total;

  search_res_t pending_results[$];

  int  mismatch_count;
  int  cycle_count;
  int  items_sent;
  int  results_seen;
  int  add_items;
  int  get_items;
  int  query_items;
  int  ignored_items;
  int  hit_total;
  int  widest_answer;
  bit  quiet_mode;

  // Clock
  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic search_req_t random_request();
    search_req_t req;
    req.op            = OP_W'($urandom());
    req.pos_x         = COORD_W'($urandom());
    req.pos_y         = COORD_W'($urandom());
    req.search_radius = RAD_W'($urandom());
    req.query_id      = ID_W'($urandom());
    return req;
  endfunction

  function automatic search_res_t make_result(bsrt_status_e status,
                                              logic signed [COORD_W-1:0] px,
                                              logic signed [COORD_W-1:0] py,
                                              logic [ID_W-1:0] pid, logic last);
    search_res_t res;
    res.status   = status;
    res.point_x  = px;
    res.point_y  = py;
    res.point_id = pid;
    res.last     = last;
    return res;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_result(search_res_t res);
    pending_results = {pending_results, res};
  endfunction

  // Advance the shadow store and queue the results one item causes
  function automatic void predict_results(search_req_t req);
    search_res_t res;
    longint      dx;
    longint      dy;
    longint      rad;
    int          hits;
    hits = 0;
    rad  = longint'(req.search_radius);
    case (req.op)
      OP_ADD: begin
        add_items++;
        if (point_total >= CAPACITY) begin
          queue_result(make_result(ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          shadow_x[point_total] = req.pos_x;
          shadow_y[point_total] = req.pos_y;
          queue_result(make_result(ST_OK, req.pos_x, req.pos_y,
                                   ID_W'(point_total), 1'b1));
          point_total++;
        end
      end
      OP_GET: begin
        get_items++;
        if (int'(req.query_id) < point_total) begin
          queue_result(make_result(ST_OK, shadow_x[req.query_id],
                                   shadow_y[req.query_id], req.query_id, 1'b1));
        end else begin
          queue_result(make_result(ST_NONE, '0, '0, '0, 1'b1));
        end
      end
      OP_QUERY: begin
        query_items++;
        for (int i = 0; i < point_total; i++) begin
          dx = longint'(shadow_x[i]) - longint'(req.pos_x);
          dy = longint'(shadow_y[i]) - longint'(req.pos_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx < rad && dy < rad && dx * dx + dy * dy < rad * rad) begin
            queue_result(make_result(ST_OK, shadow_x[i], shadow_y[i],
                                     ID_W'(i), 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          queue_result(make_result(ST_NONE, '0, '0, '0, 1'b1));
        end else begin
          // mark the final hit
          res      = pending_results.pop_back();
          res.last = 1'b1;
          queue_result(res);
        end
        hit_total += hits;
        if (hits > widest_answer) widest_answer = hits;
      end
      default: ignored_items++;
    endcase
  endfunction

  // Send one item after a random gap; predict at acceptance
  task automatic send_request(input search_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_bus.op            = req.op;
    req_bus.pos_x         = req.pos_x;
    req_bus.pos_y         = req.pos_y;
    req_bus.search_radius = req.search_radius;
    req_bus.query_id      = req.query_id;
    req_bus.valid         = 1'b1;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_results(req);
    items_sent++;
  endtask

  task automatic send_fields(input logic [OP_W-1:0] op, input int px, input int py,
                             input int radius, input int qid);
    search_req_t req;
    req.op            = op;
    req.pos_x         = COORD_W'(px);
    req.pos_y         = COORD_W'(py);
    req.search_radius = RAD_W'(radius);
    req.query_id      = ID_W'(qid);
    send_request(req);
  endtask

  // Hold the request side until every queued result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty store: query, get and the unused opcode
  task automatic test_empty_store();
    send_fields(OP_QUERY, 0, 0, 100, 0);
    send_fields(OP_GET, 0, 0, 0, 0);
    send_fields(OP_UNUSED, -1, -1, 32767, 63);
  endtask

  // Add points at the coordinate extremes, the origin and (16, -16)
  task automatic test_add_extremes();
    send_fields(OP_ADD, -32768, -32768, 0, 0);
    send_fields(OP_ADD, 32767, 32767, 32767, 63);
    send_fields(OP_ADD, 0, 0, 0, 0);
    send_fields(OP_ADD, -32768, 32767, 0, 0);
    send_fields(OP_ADD, 16, -16, 0, 0);
  endtask

  // Get known ids, the first unknown id and the top id
  task automatic test_get_by_id();
    send_fields(OP_GET, 0, 0, 0, 0);
    send_fields(OP_GET, 0, 0, 0, 4);
    send_fields(OP_GET, 0, 0, 0, 5);
    send_fields(OP_GET, 0, 0, 0, 63);
  endtask

  // Zero radius, full radius, a component on the radius, a sum on the far side, two corners
  task automatic test_query_edges();
    send_fields(OP_QUERY, 0, 0, 0, 0);
    send_fields(OP_QUERY, 0, 0, 32767, 0);
    send_fields(OP_QUERY, 0, 0, 16, 0);
    send_fields(OP_QUERY, 0, 0, 20, 0);
    send_fields(OP_QUERY, -32768, -32768, 32767, 0);
    send_fields(OP_QUERY, 32767, 32767, 1, 0);
  endtask

  // Pause the sender until a long answer has fully drained
  task automatic test_drain_pause();
    send_fields(OP_QUERY, 0, 0, 32767, 0);
    wait_results_drained();
    send_fields(OP_GET, 0, 0, 0, 2);
  endtask

  // Random mix: clustered adds, gets, queries aimed at stored points, some noise
  task automatic test_random_mix(input int item_goal);
    search_req_t req;
    int          roll;
    int          pick;
    int          counted;
    counted = 0;
    while (counted < item_goal) begin
      quiet_mode = (counted >= item_goal / 3) && (counted < item_goal / 3 + 60);
      roll = $urandom_range(0, 99);
      req  = random_request();
      if (roll < 25) begin
        req.op = OP_ADD;
        if ($urandom_range(0, 2) != 0) begin
          req.pos_x = COORD_W'($urandom_range(0, 1023) - 512);
          req.pos_y = COORD_W'($urandom_range(0, 1023) - 512);
        end
      end else if (roll < 45) begin
        req.op = OP_GET;
        if (point_total > 0 && $urandom_range(0, 3) != 0)
          req.query_id = ID_W'($urandom_range(0, point_total - 1));
      end else if (roll < 92) begin
        req.op = OP_QUERY;
        if (point_total > 0 && $urandom_range(0, 4) != 0) begin
          pick      = $urandom_range(0, point_total - 1);
          req.pos_x = shadow_x[pick] + COORD_W'($urandom_range(0, 511) - 256);
          req.pos_y = shadow_y[pick] + COORD_W'($urandom_range(0, 511) - 256);
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)      req.search_radius = RAD_W'($urandom_range(0, 512));
        else if (pick < 7) req.search_radius = RAD_W'($urandom_range(0, 4096));
        else if (pick < 9) req.search_radius = RAD_W'($urandom());
        else               req.search_radius = RAD_W'(32767);
      end else begin
        req.op = OP_UNUSED;
      end
      send_request(req);
      if (req.op != OP_UNUSED) counted++;
    end
    quiet_mode = 1'b0;
  endtask

  // Fill the store, then add past capacity, read the top entry and query the full store
  task automatic test_store_full();
    search_req_t req;
    while (point_total < CAPACITY) begin
      req    = random_request();
      req.op = OP_ADD;
      send_request(req);
    end
    send_fields(OP_ADD, 1, 1, 0, 0);
    send_fields(OP_ADD, -1, -1, 0, 0);
    send_fields(OP_GET, 0, 0, 0, CAPACITY - 1);
    send_fields(OP_QUERY, 0, 0, 32767, 0);
    send_fields(OP_QUERY, -32768, 32767, 32767, 0);
  endtask

  // Result side backpressure
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        rsp_bus.ready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rsp_bus.ready = 1'b1;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    search_res_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: st=%0d x=%0d y=%0d id=%0d last=%0b",
                   rsp_bus.status, rsp_bus.point_x, rsp_bus.point_y,
                   rsp_bus.point_id, rsp_bus.last);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.point_x !== want.point_x ||
            rsp_bus.point_y !== want.point_y || rsp_bus.point_id !== want.point_id ||
            rsp_bus.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp st=%0d x=%0d y=%0d id=%0d last=%0b, got st=%0d x=%0d y=%0d id=%0d last=%0b",
                     want.status, want.point_x, want.point_y, want.point_id, want.last,
                     rsp_bus.status, rsp_bus.point_x, rsp_bus.point_y,
                     rsp_bus.point_id, rsp_bus.last);
        end
      end
    end
  end

  initial begin
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.op            = OP_ADD;
    req_bus.pos_x         = '0;
    req_bus.pos_y         = '0;
    req_bus.search_radius = '0;
    req_bus.query_id      = '0;
    point_total           = 0;
    quiet_mode            = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_add_extremes();
    test_get_by_id();
    test_query_edges();
    test_drain_pause();
    test_random_mix(380);
    test_store_full();

    // Drain, then watch for stray results
    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d items: %0d adds, %0d gets, %0d queries, %0d ignored opcodes",
             items_sent, add_items, get_items, query_items, ignored_items);
    $display("checked %0d results, %0d query hits, widest answer %0d points, store at %0d",
             results_seen, hit_total, widest_answer, point_total);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
